FILE: src/great_arc_angle_fraction_top_macros.svh
// Assertion macros shared by the great-arc angle fraction block.
`ifndef GREAT_ARC_ANGLE_FRACTION_TOP_MACROS_SVH
`define GREAT_ARC_ANGLE_FRACTION_TOP_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define GAAF_ASSERT(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define GAAF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/gaaf_pkg.sv
// ----------------------------------------------------------------------------
// Great-arc angle fraction package
// Shared types, widths, pipeline depths and CORDIC helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package gaaf_pkg;

  localparam int COORD_W  = 16;
  localparam int IDX_W    = 16;
  localparam int WEIGHT_W = 16;

  localparam int COORD_FRAC_BITS_DEF = 14;
  localparam int INDEX_WIDTH_DEF     = 16;

  localparam int ANG_W  = 22;
  localparam logic [ANG_W-1:0] PI_Q20 = 22'd3294199;

  localparam int SQ_SPS  = 2;
  localparam int DIV_SPS = 2;
  localparam int COR_SPS = 3;

  localparam int SQ1_IN_W = 64;
  localparam int SQ2_IN_W = 62;
  localparam int SQ1_STG  = (SQ1_IN_W / 2 + SQ_SPS - 1) / SQ_SPS;
  localparam int SQ2_STG  = (SQ2_IN_W / 2 + SQ_SPS - 1) / SQ_SPS;

  localparam int MD_STEPS = 31;
  localparam int MD_STG   = (MD_STEPS + DIV_SPS - 1) / DIV_SPS;

  localparam int COR_STEPS = 21;
  localparam int COR_STG   = (COR_STEPS + COR_SPS - 1) / COR_SPS;
  localparam int CW        = 34;
  localparam int ZW        = 24;

  localparam int ANG_LAT = 3 + SQ1_STG + MD_STG + 2 + SQ2_STG + COR_STG + 1;

  localparam int RD_STEPS = WEIGHT_W;
  localparam int RD_STG   = (RD_STEPS + DIV_SPS - 1) / DIV_SPS;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [IDX_W-1:0]          point_index;
  } gaaf_req_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]    result_index;
    logic                saturated;
    logic                degenerate;
  } gaaf_rsp_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 24'sd823550;
      1:       r = 24'sd486170;
      2:       r = 24'sd256879;
      3:       r = 24'sd130396;
      4:       r = 24'sd65451;
      5:       r = 24'sd32757;
      6:       r = 24'sd16383;
      7:       r = 24'sd8192;
      8:       r = 24'sd4096;
      9:       r = 24'sd2048;
      10:      r = 24'sd1024;
      11:      r = 24'sd512;
      12:      r = 24'sd256;
      13:      r = 24'sd128;
      14:      r = 24'sd64;
      15:      r = 24'sd32;
      16:      r = 24'sd16;
      17:      r = 24'sd8;
      18:      r = 24'sd4;
      19:      r = 24'sd2;
      20:      r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Arithmetic shift that rounds toward zero.
  function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                  input int unsigned sh);
    logic signed [CW-1:0] r;
    if (v[CW-1]) begin
      r = -((-v) >>> sh);
    end else begin
      r = v >>> sh;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/gaaf_ifs.sv
// ----------------------------------------------------------------------------
// Great-arc angle fraction channels
// Valid/ready channels for requests into and results out of the block.
// ----------------------------------------------------------------------------
`default_nettype none

interface gaaf_in_if import gaaf_pkg::*; ();
  logic      valid;
  logic      ready;
  gaaf_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gaaf_out_if import gaaf_pkg::*; ();
  logic      valid;
  logic      ready;
  gaaf_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/gaaf_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, a fixed number of result bits per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module gaaf_isqrt import gaaf_pkg::*; #(
  parameter int IN_W = 64,
  parameter int SPS  = 2,
  parameter int SB_W = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IN_W-1:0]   n_i,
  input  logic [SB_W-1:0]   sb_i,
  output logic [IN_W/2-1:0] root_o,
  output logic [SB_W-1:0]   sb_o
);

  localparam int STEPS = IN_W / 2;
  localparam int STG   = (STEPS + SPS - 1) / SPS;
  localparam int RW    = STEPS + 2;

  logic [IN_W-1:0]  n_q    [STG];
  logic [RW-1:0]    rem_q  [STG];
  logic [STEPS-1:0] root_q [STG];
  logic [SB_W-1:0]  sb_q   [STG];

  for (genvar k = 0; k < STG; k++) begin : g_stg
    logic [IN_W-1:0]  n_d;
    logic [RW-1:0]    rem_d;
    logic [STEPS-1:0] root_d;
    logic [RW-1:0]    trial;

    always_comb begin
      if (k == 0) begin
        n_d    = n_i;
        rem_d  = '0;
        root_d = '0;
      end else begin
        n_d    = n_q[k-1];
        rem_d  = rem_q[k-1];
        root_d = root_q[k-1];
      end
      trial = '0;
      for (int j = 0; j < SPS; j++) begin
        if (k * SPS + j < STEPS) begin
          rem_d = {rem_d[RW-3:0], n_d[IN_W-1 -: 2]};
          n_d   = n_d << 2;
          trial = {root_d, 2'b01};
          if (rem_d >= trial) begin
            rem_d  = rem_d - trial;
            root_d = {root_d[STEPS-2:0], 1'b1};
          end else begin
            root_d = {root_d[STEPS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        sb_q[k]   <= (k == 0) ? sb_i : sb_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign root_o = root_q[STG-1];
  assign sb_o   = sb_q[STG-1];

endmodule

`default_nettype wire

FILE: src/gaaf_angle.sv
// ----------------------------------------------------------------------------
// Pipelined vector angle
// Angle between two vectors in Q.20 radians through root, divide and CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module gaaf_angle import gaaf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [COORD_W-1:0] a_i [3],
  input  logic signed [COORD_W-1:0] b_i [3],
  output logic [ANG_W-1:0]          angle_o
);

  localparam int PW    = 2 * COORD_W;
  localparam int DOT_W = PW + 2;
  localparam int QW    = MD_STEPS;
  localparam int RTW   = SQ1_IN_W / 2;
  localparam int SW    = SQ2_IN_W / 2;
  localparam logic [QW-1:0] ONE_Q30 = QW'(1) << 30;

  logic signed [PW-1:0] pab_q [3];
  logic signed [PW-1:0] paa_q [3];
  logic signed [PW-1:0] pbb_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        pab_q[c] <= a_i[c] * b_i[c];
        paa_q[c] <= a_i[c] * a_i[c];
        pbb_q[c] <= b_i[c] * b_i[c];
      end
    end
  end

  logic signed [DOT_W-1:0] dot_d;
  logic [DOT_W-1:0]        dabs;
  logic [PW-1:0]           la_d, lb_d;
  logic [PW-1:0]           la_q, lb_q, mag_q, mag3_q;
  logic                    neg_q, neg3_q;
  logic [SQ1_IN_W-1:0]     prod_q;

  always_comb begin
    dot_d = DOT_W'(pab_q[0]) + DOT_W'(pab_q[1]) + DOT_W'(pab_q[2]);
    dabs  = dot_d[DOT_W-1] ? $unsigned(-dot_d) : $unsigned(dot_d);
    la_d  = $unsigned(paa_q[0]) + $unsigned(paa_q[1]) + $unsigned(paa_q[2]);
    lb_d  = $unsigned(pbb_q[0]) + $unsigned(pbb_q[1]) + $unsigned(pbb_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      la_q   <= la_d;
      lb_q   <= lb_d;
      mag_q  <= dabs[PW-1:0];
      neg_q  <= dot_d[DOT_W-1];
      prod_q <= la_q * lb_q;
      mag3_q <= mag_q;
      neg3_q <= neg_q;
    end
  end

  logic [RTW-1:0] r_w;
  logic [PW:0]    sb1_w;

  gaaf_isqrt #(
    .IN_W (SQ1_IN_W),
    .SPS  (SQ_SPS),
    .SB_W (PW + 1)
  ) u_sq1 (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .n_i    (prod_q),
    .sb_i   ({neg3_q, mag3_q}),
    .root_o (r_w),
    .sb_o   (sb1_w)
  );

  // Long division of the dot magnitude, scaled by 2^30, by the root.
  logic [RTW:0]   md_rem_q [MD_STG];
  logic [RTW-1:0] md_d_q   [MD_STG];
  logic [QW-1:0]  md_lo_q  [MD_STG];
  logic [QW-1:0]  md_q_q   [MD_STG];
  logic           md_neg_q [MD_STG];

  for (genvar k = 0; k < MD_STG; k++) begin : g_md
    logic [RTW:0]   rem_d;
    logic [RTW:0]   rem_s;
    logic [RTW-1:0] d_d;
    logic [QW-1:0]  lo_d;
    logic [QW-1:0]  q_d;
    logic           neg_d;

    always_comb begin
      if (k == 0) begin
        d_d   = (r_w == '0) ? RTW'(1) : r_w;
        rem_d = (RTW + 1)'(sb1_w[PW-1:1]);
        lo_d  = {sb1_w[0], {(QW-1){1'b0}}};
        q_d   = '0;
        neg_d = sb1_w[PW];
      end else begin
        d_d   = md_d_q[k-1];
        rem_d = md_rem_q[k-1];
        lo_d  = md_lo_q[k-1];
        q_d   = md_q_q[k-1];
        neg_d = md_neg_q[k-1];
      end
      rem_s = '0;
      for (int j = 0; j < DIV_SPS; j++) begin
        if (k * DIV_SPS + j < MD_STEPS) begin
          rem_s = {rem_d[RTW-1:0], lo_d[QW-1]};
          lo_d  = lo_d << 1;
          if (rem_s >= {1'b0, d_d}) begin
            rem_d = rem_s - {1'b0, d_d};
            q_d   = {q_d[QW-2:0], 1'b1};
          end else begin
            rem_d = rem_s;
            q_d   = {q_d[QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        md_rem_q[k] <= rem_d;
        md_d_q[k]   <= d_d;
        md_lo_q[k]  <= lo_d;
        md_q_q[k]   <= q_d;
        md_neg_q[k] <= neg_d;
      end
    end
  end

  logic [QW-1:0]       mcl;
  logic [QW-1:0]       m1_q, m2_q;
  logic                n1_q, n2_q;
  logic [2*QW-1:0]     msq_q;
  logic [SQ2_IN_W-1:0] diff_q;

  assign mcl = (md_q_q[MD_STG-1] > ONE_Q30) ? ONE_Q30 : md_q_q[MD_STG-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      msq_q  <= mcl * mcl;
      m1_q   <= mcl;
      n1_q   <= md_neg_q[MD_STG-1];
      diff_q <= (SQ2_IN_W'(1) << 60) - SQ2_IN_W'(msq_q);
      m2_q   <= m1_q;
      n2_q   <= n1_q;
    end
  end

  logic [SW-1:0] s_w;
  logic [QW:0]   sb2_w;

  gaaf_isqrt #(
    .IN_W (SQ2_IN_W),
    .SPS  (SQ_SPS),
    .SB_W (QW + 1)
  ) u_sq2 (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .n_i    (diff_q),
    .sb_i   ({n2_q, m2_q}),
    .root_o (s_w),
    .sb_o   (sb2_w)
  );

  logic signed [CW-1:0] cx_q [COR_STG];
  logic signed [CW-1:0] cy_q [COR_STG];
  logic signed [ZW-1:0] cz_q [COR_STG];
  logic                 cn_q [COR_STG];

  for (genvar k = 0; k < COR_STG; k++) begin : g_cor
    logic signed [CW-1:0] x_d, y_d, dx, dy;
    logic signed [ZW-1:0] z_d;
    logic                 n_d;

    always_comb begin
      if (k == 0) begin
        x_d = $signed(CW'(sb2_w[QW-1:0]));
        y_d = $signed(CW'(s_w));
        z_d = '0;
        n_d = sb2_w[QW];
      end else begin
        x_d = cx_q[k-1];
        y_d = cy_q[k-1];
        z_d = cz_q[k-1];
        n_d = cn_q[k-1];
      end
      dx = '0;
      dy = '0;
      for (int j = 0; j < COR_SPS; j++) begin
        if (k * COR_SPS + j < COR_STEPS) begin
          dx = shr_tz(y_d, k * COR_SPS + j);
          dy = shr_tz(x_d, k * COR_SPS + j);
          if (!y_d[CW-1]) begin
            x_d = x_d + dx;
            y_d = y_d - dy;
            z_d = z_d + atan_q20(k * COR_SPS + j);
          end else begin
            x_d = x_d - dx;
            y_d = y_d + dy;
            z_d = z_d - atan_q20(k * COR_SPS + j);
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[k] <= x_d;
        cy_q[k] <= y_d;
        cz_q[k] <= z_d;
        cn_q[k] <= n_d;
      end
    end
  end

  logic signed [ZW-1:0] z_pos, z_fin;
  logic signed [ZW-1:0] pi_s;
  logic [ANG_W-1:0]     angle_q;

  assign pi_s = $signed(ZW'(PI_Q20));

  always_comb begin
    z_pos = cz_q[COR_STG-1][ZW-1] ? '0 : cz_q[COR_STG-1];
    z_fin = cn_q[COR_STG-1] ? (pi_s - z_pos) : z_pos;
    if (z_fin[ZW-1]) begin
      z_fin = '0;
    end else if (z_fin > pi_s) begin
      z_fin = pi_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= z_fin[ANG_W-1:0];
    end
  end

  assign angle_o = angle_q;

endmodule

`default_nettype wire

FILE: src/great_arc_angle_fraction_top.sv
// ----------------------------------------------------------------------------
// Great-arc angle fraction
// Angle from arc start to a point as a fraction of the whole arc angle.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the output is not
// stalled and returns one result per request, in order, through the two
// angle pipelines, which run side by side, then the ratio divider and one
// output register; the two square roots and the divisions settle two bits
// a stage and the CORDIC three steps a stage. A stalled output holds the
// whole pipeline, so the block never drops or repeats a request.
`default_nettype none

`include "great_arc_angle_fraction_top_macros.svh"

module great_arc_angle_fraction_top import gaaf_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int INDEX_WIDTH     = INDEX_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gaaf_in_if.sink           in_i,
  gaaf_out_if.source        out_o
);

  localparam int TOT      = ANG_LAT + RD_STG + 1;
  localparam int IDX_KEEP = (INDEX_WIDTH < IDX_W) ? INDEX_WIDTH : IDX_W;
  localparam int NW       = ANG_W + COORD_FRAC_BITS;

  logic v_q [TOT];
  logic en;

  assign en         = !v_q[TOT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TOT; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= in_i.valid;
      for (int k = 1; k < TOT; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  logic signed [COORD_W-1:0] st_w [3];
  logic signed [COORD_W-1:0] en_w [3];
  logic signed [COORD_W-1:0] pt_w [3];
  logic                      zero_in;

  always_comb begin
    st_w[0] = in_i.data.start_x;
    st_w[1] = in_i.data.start_y;
    st_w[2] = in_i.data.start_z;
    en_w[0] = in_i.data.end_x;
    en_w[1] = in_i.data.end_y;
    en_w[2] = in_i.data.end_z;
    pt_w[0] = in_i.data.point_x;
    pt_w[1] = in_i.data.point_y;
    pt_w[2] = in_i.data.point_z;
    zero_in = (st_w[0] == '0 && st_w[1] == '0 && st_w[2] == '0)
           || (en_w[0] == '0 && en_w[1] == '0 && en_w[2] == '0)
           || (pt_w[0] == '0 && pt_w[1] == '0 && pt_w[2] == '0);
  end

  logic [ANG_W-1:0] num_w, den_w;

  gaaf_angle u_ang_pt (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (st_w),
    .b_i     (pt_w),
    .angle_o (num_w)
  );

  gaaf_angle u_ang_end (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (st_w),
    .b_i     (en_w),
    .angle_o (den_w)
  );

  logic                zd_q [ANG_LAT];
  logic [IDX_KEEP-1:0] ix_q [ANG_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      zd_q[0] <= zero_in;
      ix_q[0] <= in_i.data.point_index[IDX_KEEP-1:0];
      for (int k = 1; k < ANG_LAT; k++) begin
        zd_q[k] <= zd_q[k-1];
        ix_q[k] <= ix_q[k-1];
      end
    end
  end

  // Ratio divider: a quotient of more than 16 bits is saturated up front, so
  // the remainder starts below the divisor and 16 quotient bits remain.
  logic [NW-1:0] nw_w, hi_w;
  logic          sat0, deg0;

  always_comb begin
    nw_w = NW'(num_w) << COORD_FRAC_BITS;
    hi_w = nw_w >> WEIGHT_W;
    sat0 = hi_w >= NW'(den_w);
    deg0 = zd_q[ANG_LAT-1] || (den_w == '0);
  end

  logic [ANG_W-1:0]    rd_rem_q [RD_STG];
  logic [ANG_W-1:0]    rd_den_q [RD_STG];
  logic [WEIGHT_W-1:0] rd_lo_q  [RD_STG];
  logic [WEIGHT_W-1:0] rd_q_q   [RD_STG];
  logic                rd_sat_q [RD_STG];
  logic                rd_deg_q [RD_STG];
  logic [IDX_KEEP-1:0] rd_ix_q  [RD_STG];

  for (genvar k = 0; k < RD_STG; k++) begin : g_rd
    logic [ANG_W-1:0]    rem_d, den_d;
    logic [ANG_W:0]      rem_s;
    logic [WEIGHT_W-1:0] lo_d, q_d;
    logic                sat_d, deg_d;
    logic [IDX_KEEP-1:0] ix_d;

    always_comb begin
      if (k == 0) begin
        rem_d = hi_w[ANG_W-1:0];
        den_d = den_w;
        lo_d  = nw_w[WEIGHT_W-1:0];
        q_d   = '0;
        sat_d = sat0;
        deg_d = deg0;
        ix_d  = ix_q[ANG_LAT-1];
      end else begin
        rem_d = rd_rem_q[k-1];
        den_d = rd_den_q[k-1];
        lo_d  = rd_lo_q[k-1];
        q_d   = rd_q_q[k-1];
        sat_d = rd_sat_q[k-1];
        deg_d = rd_deg_q[k-1];
        ix_d  = rd_ix_q[k-1];
      end
      rem_s = '0;
      for (int j = 0; j < DIV_SPS; j++) begin
        if (k * DIV_SPS + j < RD_STEPS) begin
          rem_s = {rem_d, lo_d[WEIGHT_W-1]};
          lo_d  = lo_d << 1;
          if (rem_s >= {1'b0, den_d}) begin
            rem_s = rem_s - {1'b0, den_d};
            q_d   = {q_d[WEIGHT_W-2:0], 1'b1};
          end else begin
            q_d   = {q_d[WEIGHT_W-2:0], 1'b0};
          end
          rem_d = rem_s[ANG_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rd_rem_q[k] <= rem_d;
        rd_den_q[k] <= den_d;
        rd_lo_q[k]  <= lo_d;
        rd_q_q[k]   <= q_d;
        rd_sat_q[k] <= sat_d;
        rd_deg_q[k] <= deg_d;
        rd_ix_q[k]  <= ix_d;
      end
    end
  end

  gaaf_rsp_t out_d, out_q;

  always_comb begin
    out_d.result_index = IDX_W'(rd_ix_q[RD_STG-1]);
    out_d.degenerate   = rd_deg_q[RD_STG-1];
    out_d.saturated    = !rd_deg_q[RD_STG-1] && rd_sat_q[RD_STG-1];
    if (rd_deg_q[RD_STG-1]) begin
      out_d.weight = '0;
    end else if (rd_sat_q[RD_STG-1]) begin
      out_d.weight = '1;
    end else begin
      out_d.weight = rd_q_q[RD_STG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = v_q[TOT-1];
  assign out_o.data  = out_q;

  `GAAF_ASSERT(a_deg_zero, clk_i, rst_ni, !out_o.valid || !out_o.data.degenerate || (out_o.data.weight == '0 && !out_o.data.saturated), "degenerate result with nonzero weight or saturation")
  `GAAF_ASSERT(a_sat_max, clk_i, rst_ni, !out_o.valid || !out_o.data.saturated || out_o.data.weight == '1, "saturated result below full scale")
  `GAAF_ASSERT(a_ang_range, clk_i, rst_ni, !v_q[ANG_LAT-1] || (num_w <= PI_Q20 && den_w <= PI_Q20), "angle beyond pi")
  `GAAF_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.data) && $stable(v_q[0]), "pipeline moved during an output stall")

endmodule

`default_nettype wire
